>>> hdl/jbsm_pkg.sv
// Shared types and codes for the bit-banged JTAG scan master.
// Used by jbsm_tap_walker and jtag_bitbang_scan_master; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jbsm_pkg;

  localparam int DR_W    = 64;
  localparam int IR_W    = 5;
  localparam int LEN_W   = 7;
  localparam int STATE_W = 4;
  localparam int ACT_W   = 3;

  // Input beat kinds.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_CLOCK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ASSERT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DONE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REQ     = 3'd4;

  // TAP walker states.
  localparam logic [STATE_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [STATE_W-1:0] ST_RESET   = 4'd1;
  localparam logic [STATE_W-1:0] ST_DRSCAN  = 4'd2;
  localparam logic [STATE_W-1:0] ST_IRSCAN  = 4'd3;
  localparam logic [STATE_W-1:0] ST_IRCAP   = 4'd4;
  localparam logic [STATE_W-1:0] ST_IRSHIFT = 4'd5;
  localparam logic [STATE_W-1:0] ST_IREXIT  = 4'd6;
  localparam logic [STATE_W-1:0] ST_IRUPD   = 4'd7;
  localparam logic [STATE_W-1:0] ST_DRCAP   = 4'd8;
  localparam logic [STATE_W-1:0] ST_DRSHIFT = 4'd9;
  localparam logic [STATE_W-1:0] ST_DREXIT  = 4'd10;
  localparam logic [STATE_W-1:0] ST_DRUPD   = 4'd11;

  localparam logic [IR_W-1:0] DMI_IR_RESET = 5'd17;

  typedef struct packed {
    logic             op;
    logic [IR_W-1:0]  req_ir;
    logic [DR_W-1:0]  req_dr;
    logic [LEN_W-1:0] req_len;
    logic             req_trst;
    logic             tdi_bit;
  } item_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             tms;
    logic             drive_bit;
    logic [DR_W-1:0]  captured_dr;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/jbsm_tap_walker.sv
// TAP walker: pending-request registers, TAP state, IR/DR shift state and the
// combinational step logic that turns one beat into one result. Uses jbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jbsm_tap_walker #(
  parameter int IR_LEN    = 5,
  parameter int ADDR_BITS = 7
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         step_en,
  input  jbsm_pkg::item_t             item,
  input  wire [jbsm_pkg::IR_W-1:0]    dmi_ir_code,
  output jbsm_pkg::result_t           result
);

  localparam int DMI_POS = (ADDR_BITS + 33) % 64;
  localparam logic [5:0] POS_DMI = 6'(DMI_POS);
  localparam logic [5:0] POS_STD = 6'd31;
  localparam logic [3:0] IR_LAST = 4'(IR_LEN);

  logic [jbsm_pkg::STATE_W-1:0] tap_state_r, tap_state_nxt;
  logic [jbsm_pkg::IR_W-1:0]    current_ir_r, current_ir_nxt;
  logic [2:0]                   ir_count_r, ir_count_nxt;
  logic [jbsm_pkg::DR_W-1:0]    dr_shift_r, dr_shift_nxt;
  logic [jbsm_pkg::LEN_W-1:0]   dr_count_r, dr_count_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic [jbsm_pkg::IR_W-1:0]    pend_ir_r, pend_ir_nxt;
  logic [jbsm_pkg::DR_W-1:0]    pend_dr_r, pend_dr_nxt;
  logic [jbsm_pkg::LEN_W-1:0]   pend_len_r, pend_len_nxt;
  logic                         pend_trst_r, pend_trst_nxt;

  logic [5:0]                   in_pos;
  logic [jbsm_pkg::DR_W-1:0]    dr_shifted;
  logic [7:0]                   ir_ext;
  logic [3:0]                   ir_cnt_inc;
  logic [jbsm_pkg::LEN_W-1:0]   dr_cnt_inc;

  // The sampled bit lands higher up when the DMI register is selected.
  assign in_pos = (current_ir_r == dmi_ir_code) ? POS_DMI : POS_STD;

  always_comb begin
    dr_shifted         = dr_shift_r >> 1;
    dr_shifted[in_pos] = dr_shifted[in_pos] | item.tdi_bit;
  end

  assign ir_ext     = {3'b000, current_ir_r};
  assign ir_cnt_inc = {1'b0, ir_count_r} + 4'd1;
  assign dr_cnt_inc = dr_count_r + 7'd1;

  always_comb begin
    tap_state_nxt  = tap_state_r;
    current_ir_nxt = current_ir_r;
    ir_count_nxt   = ir_count_r;
    dr_shift_nxt   = dr_shift_r;
    dr_count_nxt   = dr_count_r;
    pend_valid_nxt = pend_valid_r;
    pend_ir_nxt    = pend_ir_r;
    pend_dr_nxt    = pend_dr_r;
    pend_len_nxt   = pend_len_r;
    pend_trst_nxt  = pend_trst_r;
    result.action      = jbsm_pkg::ACT_CLOCK;
    result.tms         = 1'b0;
    result.drive_bit   = 1'b1;
    result.captured_dr = '0;

    if (item.op == jbsm_pkg::OP_REQUEST) begin
      // A new request overwrites the pending IR, DR and length, even mid-scan; a pending TAP reset is kept.
      pend_valid_nxt   = 1'b1;
      result.action    = jbsm_pkg::ACT_REQ;
      result.drive_bit = 1'b0;
      if (item.req_trst) begin
        pend_ir_nxt   = '0;
        pend_dr_nxt   = '0;
        pend_len_nxt  = '0;
        pend_trst_nxt = 1'b1;
      end else begin
        pend_ir_nxt  = item.req_ir;
        pend_dr_nxt  = item.req_dr;
        pend_len_nxt = item.req_len;
      end
    end else begin
      unique case (tap_state_r)
        jbsm_pkg::ST_RESET: begin
          pend_trst_nxt    = 1'b0;
          result.action    = jbsm_pkg::ACT_RELEASE;
          result.drive_bit = 1'b0;
          tap_state_nxt    = jbsm_pkg::ST_IDLE;
        end
        jbsm_pkg::ST_IDLE: begin
          if (pend_valid_r) begin
            pend_valid_nxt = 1'b0;
            if (pend_trst_r) begin
              result.action    = jbsm_pkg::ACT_ASSERT;
              result.drive_bit = 1'b0;
              tap_state_nxt    = jbsm_pkg::ST_RESET;
            end else begin
              result.tms    = 1'b1;
              tap_state_nxt = jbsm_pkg::ST_DRSCAN;
            end
          end else begin
            result.action      = jbsm_pkg::ACT_DONE;
            result.drive_bit   = 1'b0;
            result.captured_dr = dr_shift_r;
          end
        end
        jbsm_pkg::ST_DRSCAN: begin
          // Skip the IR path when the right instruction is already loaded.
          if (current_ir_r != pend_ir_r) begin
            result.tms    = 1'b1;
            tap_state_nxt = jbsm_pkg::ST_IRSCAN;
          end else begin
            tap_state_nxt = jbsm_pkg::ST_DRCAP;
          end
        end
        jbsm_pkg::ST_IRSCAN: tap_state_nxt = jbsm_pkg::ST_IRCAP;
        jbsm_pkg::ST_IRCAP: begin
          current_ir_nxt = pend_ir_r;
          ir_count_nxt   = '0;
          tap_state_nxt  = jbsm_pkg::ST_IRSHIFT;
        end
        jbsm_pkg::ST_IRSHIFT: begin
          result.drive_bit = ir_ext[ir_count_r];
          if (ir_cnt_inc == IR_LAST) begin
            result.tms    = 1'b1;
            tap_state_nxt = jbsm_pkg::ST_IREXIT;
          end
          ir_count_nxt = ir_cnt_inc[2:0];
        end
        jbsm_pkg::ST_IREXIT: begin
          result.tms    = 1'b1;
          tap_state_nxt = jbsm_pkg::ST_IRUPD;
        end
        jbsm_pkg::ST_IRUPD: begin
          result.tms    = 1'b1;
          tap_state_nxt = jbsm_pkg::ST_DRSCAN;
        end
        jbsm_pkg::ST_DRCAP: begin
          dr_shift_nxt  = pend_dr_r;
          dr_count_nxt  = '0;
          tap_state_nxt = jbsm_pkg::ST_DRSHIFT;
        end
        jbsm_pkg::ST_DRSHIFT: begin
          result.drive_bit = dr_shift_r[0];
          dr_shift_nxt     = dr_shifted;
          dr_count_nxt     = dr_cnt_inc;
          // A length of zero wraps the count and so shifts 128 bits.
          if (dr_cnt_inc == pend_len_r) begin
            result.tms    = 1'b1;
            tap_state_nxt = jbsm_pkg::ST_DREXIT;
          end
        end
        jbsm_pkg::ST_DREXIT: begin
          result.tms    = 1'b1;
          dr_shift_nxt  = dr_shifted;
          tap_state_nxt = jbsm_pkg::ST_DRUPD;
        end
        jbsm_pkg::ST_DRUPD: tap_state_nxt = jbsm_pkg::ST_IDLE;
        default: tap_state_nxt = jbsm_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_state_r  <= jbsm_pkg::ST_IDLE;
      current_ir_r <= '0;
      ir_count_r   <= '0;
      dr_shift_r   <= '0;
      dr_count_r   <= '0;
      pend_valid_r <= 1'b0;
      pend_ir_r    <= '0;
      pend_dr_r    <= '0;
      pend_len_r   <= '0;
      pend_trst_r  <= 1'b0;
    end else if (step_en) begin
      tap_state_r  <= tap_state_nxt;
      current_ir_r <= current_ir_nxt;
      ir_count_r   <= ir_count_nxt;
      dr_shift_r   <= dr_shift_nxt;
      dr_count_r   <= dr_count_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_ir_r    <= pend_ir_nxt;
      pend_dr_r    <= pend_dr_nxt;
      pend_len_r   <= pend_len_nxt;
      pend_trst_r  <= pend_trst_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/jtag_bitbang_scan_master.sv
// A beat is held in the input register, stepped by the combinational TAP walker
// and its result held in the result register until taken. Throughput: one beat
// per cycle while results are taken; a stalled result register holds the input.
// Reset: synchronous, active low; clears the walker, both valid flags and
// sets dmi_ir_code to 17.
// Top level of the JTAG scan master; uses jbsm_pkg and jbsm_tap_walker.
`timescale 1ns / 1ps
`default_nettype none
module jtag_bitbang_scan_master #(
  parameter int IR_LEN    = 5,
  parameter int ADDR_BITS = 7
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [4:0]  cfg_wdata,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_op,
  input  wire [4:0]  in_req_ir,
  input  wire [63:0] in_req_dr,
  input  wire [6:0]  in_req_len,
  input  wire        in_req_trst,
  input  wire        in_tdi_bit,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_action,
  output logic       out_tms,
  output logic       out_drive_bit,
  output logic [63:0] out_captured_dr
);

  logic [jbsm_pkg::IR_W-1:0] dmi_ir_r;
  logic                      s1_valid_r, s1_valid_nxt;
  jbsm_pkg::item_t           s1_item_r;
  logic                      out_valid_r, out_valid_nxt;
  jbsm_pkg::result_t         out_res_r;
  jbsm_pkg::result_t         step_res;
  logic                      s1_go;
  logic                      in_fire;

  // The stored beat moves on whenever the result register is free or draining.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmi_ir_r    <= jbsm_pkg::DMI_IR_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dmi_ir_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.op       <= in_op;
      s1_item_r.req_ir   <= in_req_ir;
      s1_item_r.req_dr   <= in_req_dr;
      s1_item_r.req_len  <= in_req_len;
      s1_item_r.req_trst <= in_req_trst;
      s1_item_r.tdi_bit  <= in_tdi_bit;
    end
    if (s1_go) begin
      out_res_r <= step_res;
    end
  end

  jbsm_tap_walker #(
    .IR_LEN    (IR_LEN),
    .ADDR_BITS (ADDR_BITS)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_go),
    .item        (s1_item_r),
    .dmi_ir_code (dmi_ir_r),
    .result      (step_res)
  );

  assign out_valid       = out_valid_r;
  assign out_action      = out_res_r.action;
  assign out_tms         = out_res_r.tms;
  assign out_drive_bit   = out_res_r.drive_bit;
  assign out_captured_dr = out_res_r.captured_dr;

  // A stalled result must not be replaced by the next step.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_res_r))
    else $error("result changed while stalled");

  // A buffered beat is never lost: it either moves on or stays valid.
  a_s1_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_item_r))
    else $error("buffered beat dropped");

  // Only plain clock-cycle results drive TMS high.
  a_tms_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.tms |-> out_res_r.action == jbsm_pkg::ACT_CLOCK)
    else $error("tms high on a non-clock action");

  // A request beat's result carries no TAP activity.
  a_req_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action == jbsm_pkg::ACT_REQ |->
      !out_res_r.drive_bit && out_res_r.captured_dr == '0)
    else $error("request result not quiet");

endmodule
`default_nettype wire

>>> tb/jbsm_scan_checker.sv
// Scoreboard for the bit-banged JTAG scan master: watches the input, result and
// configuration ports, predicts each result beat and compares it field by field.
// Depends on jbsm_pkg for the beat, action and walker state codes.
`timescale 1ns / 1ps
module jbsm_scan_checker #(
  parameter int IR_LEN    = 5,
  parameter int ADDR_BITS = 7
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [4:0]  cfg_wdata,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire        in_op,
  input  wire [4:0]  in_req_ir,
  input  wire [63:0] in_req_dr,
  input  wire [6:0]  in_req_len,
  input  wire        in_req_trst,
  input  wire        in_tdi_bit,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [2:0]  out_action,
  input  wire        out_tms,
  input  wire        out_drive_bit,
  input  wire [63:0] out_captured_dr,
  output int         fail_count,
  output int         open_cnt
);

  // Shadow copy of the walker, the loaded IR and the pending request.
  logic [jbsm_pkg::IR_W-1:0]    dmi_code;
  logic [jbsm_pkg::STATE_W-1:0] walk_st;
  logic [jbsm_pkg::IR_W-1:0]    cur_ir;
  logic [2:0]                   ir_cnt;
  logic [jbsm_pkg::DR_W-1:0]    dr_sh;
  logic [jbsm_pkg::LEN_W-1:0]   dr_cnt;
  logic                         pend_valid;
  logic [jbsm_pkg::IR_W-1:0]    pend_ir;
  logic [jbsm_pkg::DR_W-1:0]    pend_dr;
  logic [jbsm_pkg::LEN_W-1:0]   pend_len;
  logic                         pend_trst;

  jbsm_pkg::result_t exp_results[$];
  jbsm_pkg::item_t   beat_in;
  jbsm_pkg::result_t want;

  task automatic report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
    $display("%0t ns: check failed on %s: got %0h, expected %0h", $time, what, got_v,
             want_v);
    fail_count++;
  endtask

  // The sampled bit enters high in the shift register; the wide DMI
  // register puts it further up than the 32-bit ones.
  function automatic void capture_tdi(logic tdi);
    int pos;
    pos = (cur_ir == dmi_code) ? ((ADDR_BITS + 33) & 63) : 31;
    dr_sh = (dr_sh >> 1) | (64'(tdi) << pos);
  endfunction

  function automatic jbsm_pkg::result_t walk_tap_step(jbsm_pkg::item_t it);
    jbsm_pkg::result_t r;
    logic [7:0]        ir_word;
    r = '0;
    if (it.op == jbsm_pkg::OP_REQUEST) begin
      if (it.req_trst) begin
        pend_ir   = '0;
        pend_dr   = '0;
        pend_len  = '0;
        pend_trst = 1'b1;
      end else begin
        pend_ir  = it.req_ir;
        pend_dr  = it.req_dr;
        pend_len = it.req_len;
      end
      pend_valid = 1'b1;
      r.action   = jbsm_pkg::ACT_REQ;
      return r;
    end
    r.action    = jbsm_pkg::ACT_CLOCK;
    r.drive_bit = 1'b1;
    case (walk_st)
      jbsm_pkg::ST_RESET: begin
        pend_trst   = 1'b0;
        r.action    = jbsm_pkg::ACT_RELEASE;
        r.drive_bit = 1'b0;
        walk_st     = jbsm_pkg::ST_IDLE;
      end
      jbsm_pkg::ST_IDLE: begin
        if (pend_valid) begin
          pend_valid = 1'b0;
          if (pend_trst) begin
            r.action    = jbsm_pkg::ACT_ASSERT;
            r.drive_bit = 1'b0;
            walk_st     = jbsm_pkg::ST_RESET;
          end else begin
            r.tms   = 1'b1;
            walk_st = jbsm_pkg::ST_DRSCAN;
          end
        end else begin
          r.action      = jbsm_pkg::ACT_DONE;
          r.drive_bit   = 1'b0;
          r.captured_dr = dr_sh;
        end
      end
      jbsm_pkg::ST_DRSCAN: begin
        if (cur_ir != pend_ir) begin
          r.tms   = 1'b1;
          walk_st = jbsm_pkg::ST_IRSCAN;
        end else begin
          walk_st = jbsm_pkg::ST_DRCAP;
        end
      end
      jbsm_pkg::ST_IRSCAN: walk_st = jbsm_pkg::ST_IRCAP;
      jbsm_pkg::ST_IRCAP: begin
        cur_ir  = pend_ir;
        ir_cnt  = '0;
        walk_st = jbsm_pkg::ST_IRSHIFT;
      end
      jbsm_pkg::ST_IRSHIFT: begin
        ir_word     = 8'(cur_ir) >> ir_cnt;
        r.drive_bit = ir_word[0];
        if (int'(ir_cnt) + 1 == IR_LEN) begin
          r.tms   = 1'b1;
          walk_st = jbsm_pkg::ST_IREXIT;
        end
        ir_cnt = ir_cnt + 3'd1;
      end
      jbsm_pkg::ST_IREXIT: begin
        r.tms   = 1'b1;
        walk_st = jbsm_pkg::ST_IRUPD;
      end
      jbsm_pkg::ST_IRUPD: begin
        r.tms   = 1'b1;
        walk_st = jbsm_pkg::ST_DRSCAN;
      end
      jbsm_pkg::ST_DRCAP: begin
        dr_sh   = pend_dr;
        dr_cnt  = '0;
        walk_st = jbsm_pkg::ST_DRSHIFT;
      end
      jbsm_pkg::ST_DRSHIFT: begin
        r.drive_bit = dr_sh[0];
        capture_tdi(it.tdi_bit);
        // The 7-bit counter wraps, so a length of zero runs 128 bits.
        dr_cnt = dr_cnt + 7'd1;
        if (dr_cnt == pend_len) begin
          r.tms   = 1'b1;
          walk_st = jbsm_pkg::ST_DREXIT;
        end
      end
      jbsm_pkg::ST_DREXIT: begin
        r.tms = 1'b1;
        capture_tdi(it.tdi_bit);
        walk_st = jbsm_pkg::ST_DRUPD;
      end
      jbsm_pkg::ST_DRUPD: walk_st = jbsm_pkg::ST_IDLE;
      default: walk_st = jbsm_pkg::ST_IDLE;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      dmi_code   = jbsm_pkg::DMI_IR_RESET;
      walk_st    = jbsm_pkg::ST_IDLE;
      cur_ir     = '0;
      ir_cnt     = '0;
      dr_sh      = '0;
      dr_cnt     = '0;
      pend_valid = 1'b0;
      pend_ir    = '0;
      pend_dr    = '0;
      pend_len   = '0;
      pend_trst  = 1'b0;
      exp_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, action", 64'(out_action),
                          '0);
        end else begin
          want = exp_results.pop_front();
          if (out_action !== want.action)
            report_mismatch("action", 64'(out_action), 64'(want.action));
          if (out_tms !== want.tms)
            report_mismatch("tms", 64'(out_tms), 64'(want.tms));
          if (out_drive_bit !== want.drive_bit)
            report_mismatch("drive_bit", 64'(out_drive_bit), 64'(want.drive_bit));
          if (out_captured_dr !== want.captured_dr)
            report_mismatch("captured_dr", out_captured_dr, want.captured_dr);
        end
      end
      if (cfg_we) begin
        dmi_code = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        beat_in.op       = in_op;
        beat_in.req_ir   = in_req_ir;
        beat_in.req_dr   = in_req_dr;
        beat_in.req_len  = in_req_len;
        beat_in.req_trst = in_req_trst;
        beat_in.tdi_bit  = in_tdi_bit;
        exp_results.push_back(walk_tap_step(beat_in));
      end
    end
    open_cnt <= exp_results.size();
  end

endmodule

>>> tb/jtag_bitbang_scan_master_tb.sv
// Top of the scan master testbench: clock, reset, request and sample traffic,
// result back-pressure and the verdict. Depends on jbsm_pkg, the block and
// jbsm_scan_checker, which does all prediction and comparison.
`timescale 1ns / 1ps
module jtag_bitbang_scan_master_tb;

  localparam int IR_LEN    = 5;
  localparam int ADDR_BITS = 7;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [4:0]  cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_op       = 1'b0;
  logic [4:0]  in_req_ir   = '0;
  logic [63:0] in_req_dr   = '0;
  logic [6:0]  in_req_len  = '0;
  logic        in_req_trst = 1'b0;
  logic        in_tdi_bit  = 1'b0;
  logic        out_ready   = 1'b0;

  wire         in_ready;
  wire         out_valid;
  wire [2:0]   out_action;
  wire         out_tms;
  wire         out_drive_bit;
  wire [63:0]  out_captured_dr;

  int fail_total;
  int results_open;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int beats_sent   = 0;

  // What the stimulus believes the TAP holds in its IR, to size each scan.
  logic [jbsm_pkg::IR_W-1:0] prev_ir  = '0;
  bit                        ir_known = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jtag_bitbang_scan_master #(
    .IR_LEN   (IR_LEN),
    .ADDR_BITS(ADDR_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_req_ir      (in_req_ir),
    .in_req_dr      (in_req_dr),
    .in_req_len     (in_req_len),
    .in_req_trst    (in_req_trst),
    .in_tdi_bit     (in_tdi_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_tms        (out_tms),
    .out_drive_bit  (out_drive_bit),
    .out_captured_dr(out_captured_dr)
  );

  jbsm_scan_checker #(
    .IR_LEN   (IR_LEN),
    .ADDR_BITS(ADDR_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_req_ir      (in_req_ir),
    .in_req_dr      (in_req_dr),
    .in_req_len     (in_req_len),
    .in_req_trst    (in_req_trst),
    .in_tdi_bit     (in_tdi_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_tms        (out_tms),
    .out_drive_bit  (out_drive_bit),
    .out_captured_dr(out_captured_dr),
    .fail_count     (fail_total),
    .open_cnt       (results_open)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] pick_dr();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '1;
    if (roll < 20) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [6:0] pick_len();
    if ($urandom_range(99) < 88) return 7'($urandom_range(1, 12));
    case ($urandom_range(4))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'd127;
      3: return 7'd63;
      default: return 7'($urandom_range(13, 127));
    endcase
  endfunction

  function automatic logic [4:0] pick_ir(logic [4:0] dmi);
    case ($urandom_range(3))
      0: return dmi;
      1: return prev_ir;
      default: return 5'($urandom);
    endcase
  endfunction

  // Valid is only lowered for an idle cycle, so back-to-back beats keep it high.
  task automatic send_beat(logic op, logic [4:0] ir, logic [63:0] dr, logic [6:0] len,
                           logic trst, logic tdi);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_req_ir   <= ir;
    in_req_dr   <= dr;
    in_req_len  <= len;
    in_req_trst <= trst;
    in_tdi_bit  <= tdi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_samples(int n);
    repeat (n) begin
      send_beat(jbsm_pkg::OP_SAMPLE, 5'($urandom), {$urandom, $urandom}, 7'($urandom),
                1'($urandom), 1'($urandom));
    end
  endtask

  // A request followed by enough samples to walk it through to scan done, plus up to two more.
  task automatic run_scan(logic [4:0] ir, logic [63:0] dr, logic [6:0] len, logic trst);
    int n;
    send_beat(jbsm_pkg::OP_REQUEST, ir, dr, len, trst, 1'($urandom));
    if (trst) begin
      n = 3;
    end else begin
      n = ((ir_known && ir == prev_ir) ? 3 : 13) + ((len == 0) ? 128 : int'(len)) + 3;
      prev_ir  = ir;
      ir_known = 1'b1;
    end
    send_samples(n + $urandom_range(2));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_open != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(logic [4:0] dmi, int gap, int stall, int count);
    int stop_at;
    int roll;
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= dmi;
    @(posedge clk);
    cfg_we       <= 1'b0;
    send_gap_pct = gap;
    stall_pct    = stall;
    stop_at      = beats_sent + count;
    while (beats_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        run_scan(pick_ir(dmi), pick_dr(), pick_len(), 1'b0);
      end else if (roll < 82) begin
        run_scan(5'($urandom), {$urandom, $urandom}, 7'($urandom), 1'b1);
      end else if (roll < 92) begin
        // A second request lands after a random run of samples, which may be while the first scan is still walking.
        send_beat(jbsm_pkg::OP_REQUEST, pick_ir(dmi), pick_dr(), pick_len(), 1'b0,
                  1'($urandom));
        send_samples($urandom_range(1, 24));
        ir_known = 1'b0;
        run_scan(pick_ir(dmi), pick_dr(), pick_len(), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(1'($urandom), 5'($urandom), {$urandom, $urandom}, 7'($urandom),
                    1'($urandom), 1'($urandom));
        end
        ir_known = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sample with nothing pending, a TAP reset, then one short
    // scan into the DMI register with an all-ones value.
    send_samples(1);
    run_scan(5'($urandom), {$urandom, $urandom}, 7'($urandom), 1'b1);
    run_scan(jbsm_pkg::DMI_IR_RESET, '1, 7'd1, 1'b0);

    run_phase(5'd0, 0, 0, 225);
    run_phase(5'd31, 58, 0, 225);
    run_phase(jbsm_pkg::DMI_IR_RESET, 0, 58, 225);
    run_phase(5'($urandom), 27, 27, 225);
    drain();

    if (fail_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
